FILE: hdl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg: shared constants and helpers for the cycle/swing phase mapper
// Register indexes, default fixed-point format and saturation helper.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IDX_W         = 3;
    localparam int DATA_W        = 32;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_WAVE_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RANGE_START = 3'd1;
    localparam logic [IDX_W-1:0] REG_RANGE_END   = 3'd2;
    localparam logic [IDX_W-1:0] REG_TIME_BIAS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_TIME_SCALE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_STEP_SIZE   = 3'd5;
    localparam logic [IDX_W-1:0] REG_CYCLE_LIMIT = 3'd6;

    typedef logic signed [DATA_W-1:0] q_t;

    // clamp a 34-bit signed value to the 32-bit signed range
    function automatic q_t sat_s32(input logic signed [33:0] v);
        q_t res;
        if (v > 34'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: hdl/csp_div.sv
// ----------------------------------------------------------------------------
// csp_div: pipelined restoring unsigned divider
// One quotient bit per stage, MSB first; side data travels alongside.
// ----------------------------------------------------------------------------
module csp_div #(
    parameter int NW = 49,
    parameter int DW = 33,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [DW-1:0] out_rem,
    output logic [SW-1:0] out_side
);

    logic          valid_reg [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] nq_reg   [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          prv_valid;
        logic [DW-1:0] prv_rem;
        logic [NW-1:0] prv_nq;
        logic [DW-1:0] prv_den;
        logic [SW-1:0] prv_side;
        logic [DW:0]   trial;
        logic [DW:0]   sub;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] nq_next;

        if (k == 0) begin : g_first
            assign prv_valid = in_valid;
            assign prv_rem   = '0;
            assign prv_nq    = in_num;
            assign prv_den   = in_den;
            assign prv_side  = in_side;
        end else begin : g_rest
            assign prv_valid = valid_reg[k-1];
            assign prv_rem   = rem_reg[k-1];
            assign prv_nq    = nq_reg[k-1];
            assign prv_den   = den_reg[k-1];
            assign prv_side  = side_reg[k-1];
        end

        // shift in the next numerator bit, subtract if it fits
        assign trial    = {prv_rem, prv_nq[NW-1]};
        assign ge       = trial >= {1'b0, prv_den};
        assign sub      = trial - {1'b0, prv_den};
        assign rem_next = ge ? sub[DW-1:0] : trial[DW-1:0];
        assign nq_next  = {prv_nq[NW-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= prv_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                nq_reg[k]   <= nq_next;
                den_reg[k]  <= prv_den;
                side_reg[k] <= prv_side;
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign out_quo   = nq_reg[NW-1];
    assign out_rem   = rem_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

FILE: hdl/cycle_swing_phase_mapper.sv
// ----------------------------------------------------------------------------
// cycle_swing_phase_mapper: time sample to sawtooth / triangle animation value
// Bias, scale, normalise into cycles, fold to a phase and map back onto the
// output range, with optional step flooring; all signed fixed point.
// ----------------------------------------------------------------------------
//
//  channel  | ports                            | payload
//  ---------+----------------------------------+-------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser| time_value / time_present
//  result   | m_tvalid m_tready m_tdata        | anim_value
//  config   | cfg_valid cfg_ready cfg_index    | register write, cfg_data
//
//  One item per cycle while the result is not stalled; the pipeline depth is
//  led by the two bit-per-stage divider chains (phase normalisation,
//  33 + FRAC_BITS stages, Q16.16 by default; step remainder, 32 stages).
//  Reset (aresetn low, synchronous) empties the pipeline and loads register
//  defaults. A stalled result holds the whole pipeline; the next item is
//  taken whenever the output register is empty or being drained.
//
module cycle_swing_phase_mapper #(
    parameter int FRAC_BITS = csp_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] time_value
    input  logic [0:0]  s_tuser,     // [0] time_present
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] anim_value
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NW1 = 33 + FRAC_BITS;       // normalise numerator width
    localparam int DW1 = 33;                   // normalise divisor width
    localparam int NW2 = 32;                   // step numerator width
    localparam int DW2 = 31;                   // step divisor width
    localparam int PW  = FRAC_BITS + 1;        // phase width, 0 to 1.0
    localparam int MW  = PW + 32;              // phase times span
    localparam int SHW = 64 - FRAC_BITS;       // shifted product width
    localparam logic [PW-1:0] ONE_Q  = PW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF_Q = PW'(1) << (FRAC_BITS - 1);

    // ---------------- configuration registers ----------------
    logic               wave_mode_reg;
    logic signed [31:0] range_start_reg;
    logic signed [31:0] range_end_reg;
    logic signed [31:0] time_bias_reg;
    logic signed [31:0] time_scale_reg;
    logic [30:0]        step_size_reg;
    logic [30:0]        cycle_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_mode_reg   <= 1'b0;
            range_start_reg <= '0;
            range_end_reg   <= 32'(ONE_Q);
            time_bias_reg   <= '0;
            time_scale_reg  <= 32'(ONE_Q);
            step_size_reg   <= '0;
            cycle_limit_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                csp_pkg::REG_WAVE_MODE:   wave_mode_reg   <= cfg_data[0];
                csp_pkg::REG_RANGE_START: range_start_reg <= cfg_data;
                csp_pkg::REG_RANGE_END:   range_end_reg   <= cfg_data;
                csp_pkg::REG_TIME_BIAS:   time_bias_reg   <= cfg_data;
                csp_pkg::REG_TIME_SCALE:  time_scale_reg  <= cfg_data;
                csp_pkg::REG_STEP_SIZE:   step_size_reg   <= cfg_data[30:0];
                csp_pkg::REG_CYCLE_LIMIT: cycle_limit_reg <= cfg_data[30:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // span and divisor follow the registers; the user must change them only while idle (not enforced here)
    logic signed [32:0] span;
    logic               span_pos;
    logic [31:0]        span_u;
    logic [DW1-1:0]     den1;

    assign span     = 33'(range_end_reg) - 33'(range_start_reg);
    assign span_pos = span > 33'sd0;
    assign span_u   = span[31:0];
    // swing mode halves the cycle count: double the divisor
    assign den1     = wave_mode_reg ? {span_u, 1'b0} : {1'b0, span_u};

    // ---------------- global advance ----------------
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: bias ----------------
    logic               s1_valid_reg, s1_ok_reg;
    logic signed [31:0] s1_biased_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ok_reg     <= s_tuser[0];
            s1_biased_reg <= csp_pkg::sat_s32(34'(time_bias_reg) + 34'(signed'(s_tdata)));
        end
    end

    // ---------------- stage 2: scale multiply ----------------
    logic               s2_valid_reg, s2_ok_reg;
    logic signed [63:0] s2_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_ok_reg   <= s1_ok_reg;
            s2_prod_reg <= 64'(time_scale_reg) * 64'(s1_biased_reg);
        end
    end

    // ---------------- stage 3: floor shift and saturate ----------------
    logic signed [SHW-1:0] shifted;
    logic signed [31:0]    scaled;
    logic                  s3_valid_reg, s3_ok_reg;
    logic signed [31:0]    s3_scaled_reg;

    assign shifted = s2_prod_reg[63:FRAC_BITS];   // arithmetic shift keeps floor

    always_comb begin
        if (shifted > SHW'(32'sh7FFF_FFFF)) begin
            scaled = 32'sh7FFF_FFFF;
        end else if (shifted < -(SHW'(33'sh0_8000_0000))) begin
            scaled = 32'sh8000_0000;
        end else begin
            scaled = shifted[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_ok_reg     <= s2_ok_reg && span_pos;
            s3_scaled_reg <= scaled;
        end
    end

    // ---------------- stage 4: offset from start, sign and magnitude -------
    logic signed [32:0] diff;
    logic               s4_valid_reg, s4_ok_reg, s4_neg_reg;
    logic [32:0]        s4_mag_reg;

    assign diff = 33'(s3_scaled_reg) - 33'(range_start_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_ok_reg  <= s3_ok_reg;
            s4_neg_reg <= diff[32];
            s4_mag_reg <= diff[32] ? 33'(-diff) : 33'(diff);
        end
    end

    // ---------------- normalise: |diff| * 2^F / divisor ----------------
    logic           d1_valid;
    logic [NW1-1:0] d1_quo;
    logic [DW1-1:0] d1_rem;
    logic [1:0]     d1_side;

    csp_div #(
        .NW (NW1),
        .DW (DW1),
        .SW (2)
    ) u_norm_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .in_num    ({s4_mag_reg, FRAC_BITS'(0)}),
        .in_den    (den1),
        .in_side   ({s4_ok_reg, s4_neg_reg}),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_rem   (d1_rem),
        .out_side  (d1_side)
    );

    // ---------------- stage 5: phase selection ----------------
    logic                 d1_neg, d1_rnz;
    logic [FRAC_BITS-1:0] norm_lo;
    logic [PW-1:0]        phase_next;
    logic                 s5_valid_reg, s5_ok_reg;
    logic [PW-1:0]        s5_phase_reg;

    assign d1_neg = d1_side[0];
    assign d1_rnz = |d1_rem;
    // floor of a negative quotient: -q - (remainder non-zero)
    assign norm_lo = d1_neg ? (~d1_quo[FRAC_BITS-1:0] + FRAC_BITS'(!d1_rnz))
                            : d1_quo[FRAC_BITS-1:0];

    always_comb begin
        if (cycle_limit_reg == '0) begin
            phase_next = {1'b0, norm_lo};
        end else if (d1_neg) begin
            phase_next = '0;
        end else if (d1_quo >= NW1'(cycle_limit_reg)) begin
            // whole cycle limit ends on the end value in cycle mode
            if (cycle_limit_reg[FRAC_BITS-1:0] == '0 && !wave_mode_reg) begin
                phase_next = ONE_Q;
            end else begin
                phase_next = {1'b0, cycle_limit_reg[FRAC_BITS-1:0]};
            end
        end else begin
            phase_next = {1'b0, d1_quo[FRAC_BITS-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s5_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_ok_reg    <= d1_side[1];
            s5_phase_reg <= phase_next;
        end
    end

    // ---------------- stage 6: sawtooth or triangle factor ----------------
    logic [PW-1:0] factor_next;
    logic [PW-1:0] rev_phase;
    logic          s6_valid_reg, s6_ok_reg;
    logic [PW-1:0] s6_factor_reg;

    assign rev_phase = ONE_Q - s5_phase_reg;

    always_comb begin
        if (!wave_mode_reg) begin
            factor_next = s5_phase_reg;
        end else if (s5_phase_reg < HALF_Q) begin
            factor_next = {s5_phase_reg[PW-2:0], 1'b0};
        end else begin
            factor_next = {rev_phase[PW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
        end else if (en) begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_ok_reg     <= s5_ok_reg;
            s6_factor_reg <= factor_next;
        end
    end

    // ---------------- stage 7: denormalise onto the span ----------------
    logic          s7_valid_reg, s7_ok_reg;
    logic [MW-1:0] s7_prod_reg;
    logic [31:0]   value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_valid_reg <= 1'b0;
        end else if (en) begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s7_ok_reg   <= s6_ok_reg;
            s7_prod_reg <= MW'(s6_factor_reg) * MW'(span_u);
        end
    end

    // factor never exceeds 1.0, so the value stays within the span
    assign value = s7_prod_reg[FRAC_BITS+31:FRAC_BITS];

    // ---------------- step remainder ----------------
    logic           d2_valid;
    logic [NW2-1:0] d2_quo;
    logic [DW2-1:0] d2_rem;
    logic [32:0]    d2_side;

    csp_div #(
        .NW (NW2),
        .DW (DW2),
        .SW (33)
    ) u_step_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s7_valid_reg),
        .in_num    (value),
        .in_den    (step_size_reg),
        .in_side   ({s7_ok_reg, value}),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_rem   (d2_rem),
        .out_side  (d2_side)
    );

    // ---------------- output stage: floor to step, add start ----------------
    logic [31:0]        stepped;
    logic signed [33:0] sum;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;

    assign stepped = (step_size_reg == '0) ? d2_side[31:0]
                                           : d2_side[31:0] - 32'(d2_rem);
    assign sum     = signed'({2'b00, stepped}) + 34'(range_start_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // absent time or empty span: hold at range start
            out_data_reg <= d2_side[32] ? csp_pkg::sat_s32(sum) : range_start_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- checks ----------------
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s5_valid_reg |-> (s5_phase_reg <= ONE_Q))
        else $error("phase above one");

    a_factor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s6_valid_reg |-> (s6_factor_reg <= ONE_Q))
        else $error("wave factor above one");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(s1_valid_reg) && $stable(s7_valid_reg)))
        else $error("pipeline moved during a stall");

    a_step_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (d2_valid && step_size_reg != '0) |-> (d2_rem < step_size_reg))
        else $error("step remainder not below step size");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the cycle/swing phase mapper
// Configures the mapper over several settings, sends directed and random time
// items with bursty input and a stalling receiver, and compares every result
// with an in-bench prediction of the waveform mapping.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB      = 16;
    localparam int LATENCY = 40 + 33 + FB;
    localparam longint ONE  = 64'sd1 << FB;
    localparam longint HALF = 64'sd1 << (FB - 1);
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam int LIMIT_CYCLES = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // shadow copy of the register file
    logic        sh_swing;
    logic [31:0] sh_start, sh_end, sh_bias, sh_scale;
    logic [30:0] sh_step, sh_limit;

    logic [31:0] expected_anim[$];
    int          fail_count = 0;
    int          sent_count = 0;
    longint      cycle_count = 0;
    int          hold_off = 0;   // long receiver stall, counted down by the receiver
    bit          sender_gaps = 1'b1;

    cycle_swing_phase_mapper #(.FRAC_BITS(FB)) u_dut (.*);

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic longint clamp32(input longint v);
        return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
    endfunction

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic logic [31:0] map_time(input logic [31:0] tv, input logic present);
        longint start, span, biased, scaled, denom, norm, lim, phase, value;
        longint unsigned prod;
        start = longint'($signed(sh_start));
        span  = longint'($signed(sh_end)) - start;
        if (!present || span <= 0) return sh_start;
        biased = clamp32(longint'($signed(sh_bias)) + longint'($signed(tv)));
        // arithmetic shift is a floor for a signed product
        scaled = clamp32((longint'($signed(sh_scale)) * biased) >>> FB);
        denom  = sh_swing ? 2 * span : span;
        norm   = floor_div((scaled - start) * ONE, denom);
        lim    = longint'(sh_limit);
        if (lim == 0)         phase = norm & (ONE - 1);
        else if (norm < 0)    phase = 0;
        else if (norm >= lim) begin
            phase = lim & (ONE - 1);
            if (phase == 0 && !sh_swing) phase = ONE;
        end else              phase = norm & (ONE - 1);
        if (!sh_swing)          prod = phase * span;
        else if (phase < HALF)  prod = 2 * phase * span;
        else                    prod = 2 * (ONE - phase) * span;
        value = longint'(prod >> FB);
        if (sh_step != 0) value -= value % longint'(sh_step);
        return 32'(clamp32(value + start));
    endfunction

    function automatic void set_defaults();
        sh_swing = 1'b0;
        sh_start = 32'h0;
        sh_end   = 32'h0001_0000;
        sh_bias  = 32'h0;
        sh_scale = 32'h0001_0000;
        sh_step  = '0;
        sh_limit = '0;
    endfunction

    // ------------------------------------------------------------------------
    // result checking and receiver stall pattern
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_anim.size() == 0) begin
                $error("unexpected anim_value result %h", m_tdata);
                fail_count++;
            end else begin
                logic [31:0] want;
                want = expected_anim.pop_front();
                if (m_tdata !== want) begin
                    $error("anim_value mismatch: expected %h actual %h", want, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            // stall on a slowly varying pattern: long ready stretches, some dips
            m_tready <= ((cycle_count / 200) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            csp_pkg::REG_WAVE_MODE:   sh_swing = val[0];
            csp_pkg::REG_RANGE_START: sh_start = val;
            csp_pkg::REG_RANGE_END:   sh_end   = val;
            csp_pkg::REG_TIME_BIAS:   sh_bias  = val;
            csp_pkg::REG_TIME_SCALE:  sh_scale = val;
            csp_pkg::REG_STEP_SIZE:   sh_step  = val[30:0];
            csp_pkg::REG_CYCLE_LIMIT: sh_limit = val[30:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input logic swing, input logic [31:0] st, en, bi, sc,
                           input logic [31:0] stp, lim);
        write_reg(csp_pkg::REG_WAVE_MODE, {31'd0, swing});
        write_reg(csp_pkg::REG_RANGE_START, st);
        write_reg(csp_pkg::REG_RANGE_END, en);
        write_reg(csp_pkg::REG_TIME_BIAS, bi);
        write_reg(csp_pkg::REG_TIME_SCALE, sc);
        write_reg(csp_pkg::REG_STEP_SIZE, stp);
        write_reg(csp_pkg::REG_CYCLE_LIMIT, lim);
    endtask

    // send one item; valid stays high from one item into the next, and a gap
    // (when drawn) lowers it only before the next raise
    task automatic send_time(input logic [31:0] tv, input logic present);
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tv;
        s_tuser  <= present;
        do @(posedge aclk); while (!s_tready);
        expected_anim.push_back(map_time(tv, present));
        sent_count++;
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_anim.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($urandom_range(0, 3 << FB));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed;
        logic [31:0] edges[8];
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'h0000_8000, 32'h0001_8000, 32'h5555_AAAA};
        // reset defaults, sawtooth over one unit
        foreach (edges[i]) send_time(edges[i], 1'b1);
        send_time(32'h1234_5678, 1'b0);     // time absent
        drain();
        // swing with an integer cycle limit ends at start
        set_all(1'b1, 32'hFFFF_0000, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0002_0000);
        foreach (edges[i]) send_time(edges[i], 1'b1);
        drain();
        // sawtooth with integer and fractional cycle limits, steps, and saturation
        set_all(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_time(32'h7FFF_FFFF, 1'b1);
        send_time(32'h8000_0000, 1'b1);
        drain();
        set_all(1'b0, 32'h0, 32'h0005_0000, 32'h0, 32'h0001_0000, 32'h0000_4000, 32'h0001_0000);
        send_time(32'h0009_0000, 1'b1);
        send_time(32'hFFFF_0000, 1'b1);
        send_time(32'h0002_0000, 1'b1);
        drain();
        // empty span returns start
        set_all(1'b0, 32'h0002_0000, 32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
        send_time(32'h0001_0000, 1'b1);
        drain();
    endtask

    task automatic test_random_settings;
        for (int ph = 0; ph < 12; ph++) begin
            logic [31:0] st, en;
            st = (ph % 4 == 0) ? $urandom : 32'($signed($urandom_range(0, 4 << FB)) - (2 << FB));
            en = (ph % 5 == 4) ? st - 32'd1
                 : 32'(st + $urandom_range(1, (ph % 3 == 0) ? 32'h7FFF_FFFF : (6 << FB)));
            set_all(1'($urandom), st, en,
                    (ph % 3 == 0) ? $urandom : 32'($signed($urandom_range(0, 2 << FB)) - (1 << FB)),
                    (ph % 3 == 0) ? $urandom : 32'($urandom_range(0, 4 << FB)),
                    ($urandom_range(0, 2) == 0) ? 32'h0 : 32'($urandom_range(1, 1 << FB)),
                    ($urandom_range(0, 2) == 0) ? 32'h0
                     : (($urandom_range(0, 1) == 0) ? 32'($urandom_range(1, 4)) << FB
                                                    : 32'($urandom_range(1, 4 << FB))));
            sender_gaps = (ph % 4 != 1);   // some phases send back to back
            repeat (100) send_time(rand_time(), $urandom_range(0, 9) != 0);
            drain();
        end
        sender_gaps = 1'b1;
    endtask

    task automatic test_backpressure;
        set_all(1'b1, 32'h0, 32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
        hold_off = 300;          // receiver holds off; pipeline fills and stalls input
        repeat (140) send_time(rand_time(), 1'b1);
        drain();
    endtask

    initial begin
        set_defaults();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_settings();
        if (fail_count == 0 && expected_anim.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
